/* rtl/core/cda_pkg.sv */
// cda_pkg: shared types, request codes and calendar tables for the date adder
// used by cda_leap, cda_step and calendar_date_adder
package cda_pkg;

  localparam logic [2:0] REQ_SET_DATE  = 3'd0;
  localparam logic [2:0] REQ_SET_DAY   = 3'd1;
  localparam logic [2:0] REQ_SET_MONTH = 3'd2;
  localparam logic [2:0] REQ_SET_YEAR  = 3'd3;
  localparam logic [2:0] REQ_ADD_DAYS  = 3'd4;

  localparam logic [15:0] YEAR_MIN     = 16'd1500;
  localparam logic [15:0] YEAR_DEFAULT = 16'd1900;
  localparam logic [15:0] YEAR_MAX     = 16'hFFFF;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;

  // (y * 5243) >> 19 is exactly y / 100 whenever 100 divides a 16-bit y,
  // and otherwise never times 100 back to y, which is all the leap test needs
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
    logic [15:0] add_count;
  } req_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic [8:0]  day_of_year;
    logic [8:0]  days_left;
    logic        leap_flag;
    logic        year_fixed;
    logic        month_fixed;
    logic        day_fixed;
    logic        year_overflow;
  } rsp_t;

  // result of one month step of the add sequencer
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [16:0] left;
    logic        overflow;
    logic        year_inc;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_WAIT,
    ST_LEAP_LOAD,
    ST_DAY_CHECK,
    ST_ADD_STEP,
    ST_FINISH
  } state_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    begin
      case (month)
        4'd2:                      d = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
        default:                   d = 5'd31;
      endcase
      return d;
    end
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] c;
    begin
      case (month)
        4'd2:    c = 9'd31;
        4'd3:    c = 9'd59;
        4'd4:    c = 9'd90;
        4'd5:    c = 9'd120;
        4'd6:    c = 9'd151;
        4'd7:    c = 9'd181;
        4'd8:    c = 9'd212;
        4'd9:    c = 9'd243;
        4'd10:   c = 9'd273;
        4'd11:   c = 9'd304;
        4'd12:   c = 9'd334;
        default: c = 9'd0;
      endcase
      return c;
    end
  endfunction

endpackage

/* rtl/core/cda_leap.sv */
// cda_leap: leap year unit (registered divide by 100, then compare)
// depends on cda_pkg
module cda_leap (
  input  logic        clk,
  input  logic [15:0] year,
  output logic        leap_now
);

  logic [28:0] prod;
  logic [9:0]  quot;
  logic [16:0] hund;
  logic        div100;

  assign prod = 29'(year) * 29'(cda_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    quot <= prod[cda_pkg::DIV100_SHIFT +: 10];
  end

  // quot * 100 as shifts and adds
  assign hund   = 17'({quot, 6'b0}) + 17'({quot, 5'b0}) + 17'({quot, 2'b0});
  assign div100 = (hund == {1'b0, year});

  // divisible by 400 means divisible by 100 with a quotient divisible by 4
  assign leap_now = div100 ? (quot[1:0] == 2'b00) : (year[1:0] == 2'b00);

endmodule

/* rtl/core/cda_step.sv */
// cda_step: one month step of the add-days sequencer
// depends on cda_pkg (step_t, days_in)
module cda_step (
  input  logic               [4:0]  day,
  input  logic               [3:0]  month,
  input  logic               [15:0] year,
  input  logic                      leap,
  input  logic               [16:0] left,
  output cda_pkg::step_t            step
);

  logic [4:0]  dim;
  logic [4:0]  room;
  logic        carry;
  logic [17:0] rest;

  assign dim  = cda_pkg::days_in(month, leap);
  assign room = dim - day;
  // a day past the month end always carries
  assign carry = (day > dim) || (left > {12'b0, room});
  assign rest  = {1'b0, left} + 18'(day) - 18'(dim) - 18'd1;

  always_comb begin
    step          = '0;
    step.day      = day;
    step.month    = month;
    step.year     = year;
    step.left     = left;
    step.overflow = 1'b0;
    step.year_inc = 1'b0;
    if (!carry) begin
      step.day  = day + left[4:0];
      step.left = '0;
    end else if (month != cda_pkg::MONTH_DEC) begin
      step.month = month + 4'd1;
      step.day   = 5'd1;
      step.left  = rest[16:0];
    end else if (year == cda_pkg::YEAR_MAX) begin
      step.day      = 5'd31;
      step.month    = cda_pkg::MONTH_DEC;
      step.left     = '0;
      step.overflow = 1'b1;
    end else begin
      step.year     = year + 16'd1;
      step.month    = 4'd1;
      step.day      = 5'd1;
      step.left     = rest[16:0];
      step.year_inc = 1'b1;
    end
  end

endmodule

/* rtl/core/calendar_date_adder.sv */
// calendar_date_adder: Gregorian date register with set and add-days requests
// depends on cda_pkg, cda_leap, cda_step
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request per
//   transaction: set date, set day, set month, set year or add days.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one result per request:
//   the date after it, day of year, days left, leap flag, fix flags and overflow flag.
//   One request is worked at a time; req_stall is high until it has finished.
//   States from acceptance to rsp_valid, ending in the final load:
//     set month, unused codes: none before it; set day: day check
//     set year: leap wait and load; set date: leap wait and load, day check
//     add days: one month step per month crossed and for the last partial
//     month, a leap wait and load per year crossed, and a last step that
//     finds the count at zero
//   The result waits in an output register; while rsp_stall is high the next
//   request is still accepted and worked, and only its final load waits.
//   Reset (rst, synchronous) sets the date to 1900-01-01 and empties the
//   output register.
module calendar_date_adder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cda_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cda_pkg::rsp_t  rsp
);

  cda_pkg::state_t state, state_next;

  logic [4:0]  day_reg, day_reg_next;
  logic [3:0]  month_reg, month_reg_next;
  logic [15:0] year_reg, year_reg_next;
  logic        leap, leap_next;
  logic [16:0] left, left_next;
  logic [2:0]  req_q, req_q_next;
  logic [5:0]  nday_q, nday_q_next;
  logic        yf, yf_next;
  logic        mf, mf_next;
  logic        df, df_next;
  logic        of, of_next;
  logic        rsp_valid_next;
  cda_pkg::rsp_t rsp_next;

  logic           leap_now;
  cda_pkg::step_t step;

  cda_leap u_leap (
    .clk      (clk),
    .year     (year_reg),
    .leap_now (leap_now)
  );

  cda_step u_step (
    .day   (day_reg),
    .month (month_reg),
    .year  (year_reg),
    .leap  (leap),
    .left  (left),
    .step  (step)
  );

  assign req_stall = (state != cda_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cda_pkg::ST_IDLE;
      day_reg   <= 5'd1;
      month_reg <= 4'd1;
      year_reg  <= cda_pkg::YEAR_DEFAULT;
      leap      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      day_reg   <= day_reg_next;
      month_reg <= month_reg_next;
      year_reg  <= year_reg_next;
      leap      <= leap_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    left   <= left_next;
    req_q  <= req_q_next;
    nday_q <= nday_q_next;
    yf     <= yf_next;
    mf     <= mf_next;
    df     <= df_next;
    of     <= of_next;
    rsp    <= rsp_next;
  end

  always_comb begin
    logic [4:0] dim;
    logic [8:0] doy;
    logic [8:0] total;
    state_next     = state;
    day_reg_next   = day_reg;
    month_reg_next = month_reg;
    year_reg_next  = year_reg;
    leap_next      = leap;
    left_next      = left;
    req_q_next     = req_q;
    nday_q_next    = nday_q;
    yf_next        = yf;
    mf_next        = mf;
    df_next        = df;
    of_next        = of;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    dim   = cda_pkg::days_in(month_reg, leap);
    doy   = 9'(day_reg) + cda_pkg::cum_days(month_reg)
          + 9'(leap && (month_reg > 4'd2));
    total = leap ? cda_pkg::DAYS_LEAP : cda_pkg::DAYS_COMMON;

    unique case (state)
      cda_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_q_next  = req.req_type;
          nday_q_next = req.new_day;
          left_next   = {1'b0, req.add_count};
          yf_next     = 1'b0;
          mf_next     = 1'b0;
          df_next     = 1'b0;
          of_next     = 1'b0;
          if (req.req_type inside {cda_pkg::REQ_SET_DATE, cda_pkg::REQ_SET_YEAR}) begin
            if (req.new_year >= cda_pkg::YEAR_MIN) begin
              year_reg_next = req.new_year;
            end else begin
              year_reg_next = cda_pkg::YEAR_DEFAULT;
              yf_next       = 1'b1;
            end
          end
          if (req.req_type inside {cda_pkg::REQ_SET_DATE, cda_pkg::REQ_SET_MONTH}) begin
            if (req.new_month >= 4'd1 && req.new_month <= cda_pkg::MONTH_DEC) begin
              month_reg_next = req.new_month;
            end else begin
              month_reg_next = 4'd1;
              mf_next        = 1'b1;
            end
          end
          case (req.req_type)
            cda_pkg::REQ_SET_DATE, cda_pkg::REQ_SET_YEAR: state_next = cda_pkg::ST_LEAP_WAIT;
            cda_pkg::REQ_SET_DAY:                         state_next = cda_pkg::ST_DAY_CHECK;
            cda_pkg::REQ_ADD_DAYS:                        state_next = cda_pkg::ST_ADD_STEP;
            default:                                      state_next = cda_pkg::ST_FINISH;
          endcase
        end
      end
      cda_pkg::ST_LEAP_WAIT: begin
        state_next = cda_pkg::ST_LEAP_LOAD;
      end
      cda_pkg::ST_LEAP_LOAD: begin
        leap_next = leap_now;
        case (req_q)
          cda_pkg::REQ_ADD_DAYS: state_next = cda_pkg::ST_ADD_STEP;
          cda_pkg::REQ_SET_DATE: state_next = cda_pkg::ST_DAY_CHECK;
          default:               state_next = cda_pkg::ST_FINISH;
        endcase
      end
      cda_pkg::ST_DAY_CHECK: begin
        if (nday_q >= 6'd1 && nday_q <= 6'(dim)) begin
          day_reg_next = nday_q[4:0];
        end else begin
          day_reg_next = 5'd1;
          df_next      = 1'b1;
        end
        state_next = cda_pkg::ST_FINISH;
      end
      cda_pkg::ST_ADD_STEP: begin
        if (left == '0) begin
          state_next = cda_pkg::ST_FINISH;
        end else begin
          day_reg_next   = step.day;
          month_reg_next = step.month;
          year_reg_next  = step.year;
          left_next      = step.left;
          if (step.overflow) begin
            of_next    = 1'b1;
            state_next = cda_pkg::ST_FINISH;
          end else if (step.year_inc) begin
            // leap flag must follow the new year before the next step
            state_next = cda_pkg::ST_LEAP_WAIT;
          end
        end
      end
      cda_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.cur_day       = day_reg;
          rsp_next.cur_month     = month_reg;
          rsp_next.cur_year      = year_reg;
          rsp_next.day_of_year   = doy;
          rsp_next.days_left     = (total >= doy) ? (total - doy) : 9'd0;
          rsp_next.leap_flag     = leap;
          rsp_next.year_fixed    = yf;
          rsp_next.month_fixed   = mf;
          rsp_next.day_fixed     = df;
          rsp_next.year_overflow = of;
          rsp_valid_next         = 1'b1;
          state_next             = cda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cda_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    month_reg >= 4'd1 && month_reg <= cda_pkg::MONTH_DEC)
    else $error("month register out of range");

  a_year_floor: assert property (@(posedge clk) disable iff (rst)
    year_reg >= cda_pkg::YEAR_MIN)
    else $error("year register below floor");

  a_leap_tracks_year: assert property (@(posedge clk) disable iff (rst)
    state == cda_pkg::ST_ADD_STEP |-> leap == leap_now)
    else $error("leap flag stale during add step");

  a_add_done: assert property (@(posedge clk) disable iff (rst)
    state == cda_pkg::ST_ADD_STEP && left == '0 |=> state == cda_pkg::ST_FINISH)
    else $error("add sequencer did not finish on zero count");

  a_overflow_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.year_overflow |-> rsp.cur_year == cda_pkg::YEAR_MAX
      && rsp.cur_month == cda_pkg::MONTH_DEC && rsp.cur_day == 5'd31)
    else $error("overflow result not clamped");
`endif

endmodule
